@@ rtl/itbd_pkg.sv @@
// shared types and constants for the integer to base digits block
`timescale 1ns / 1ps
`default_nettype none
package itbd_pkg;

    typedef logic [7:0] t_char;

    localparam int MAX_DIGITS   = 32;
    localparam int ALPHA_BYTES  = 16;

    localparam t_char CH_PLUS   = 8'h2B;
    localparam t_char CH_MINUS  = 8'h2D;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [1:0] REG_BASE_SIZE  = 2'd2;

endpackage
`default_nettype wire

@@ rtl/integer_to_base_digits_core.sv @@
// integer to base digits: converts a signed 32-bit value to alphabet characters
//
// input channel: i_valid/o_ready with i_value, one word per conversion.
// output channel: o_valid/i_ready with o_out_char, o_is_last, o_invalid_base.
// a negative value yields a minus character first, then the digits, most
// significant first; is_last marks the final character of each value.
// an invalid alphabet yields a single word with invalid_base set and char 0.
// digits come from a shared divider that retires 4 quotient bits a cycle.
// a value is divided digit by digit in ST_DIV, least significant first; then
// ST_SIGN emits any minus, and each digit is read back in ST_RD and emitted
// in ST_PUT; a new word is taken only once the last character has been
// loaded into the output register; an invalid alphabet skips the division.
// o_ready is high only while no conversion is in flight; the last character
// may still sit in the output register when the next word is taken.
// a receiver stall freezes the sequencer in its emit state; nothing is lost.
// reset (synchronous, active low) clears the alphabet, base size and control
// state; the digit memory needs no clearing since every entry read was
// written earlier by the same conversion.
// the configuration port is a 64-bit apb-style port, registers at 0, 8, 16;
// the user must keep them written only while the block is idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_base_digits_core #(
    parameter int MAX_RADIX = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // configuration port
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire  [4:0]            paddr,
    input  wire  [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    // input channel
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire  [31:0]           i_value,
    // output channel
    output logic                  o_valid,
    input  wire                   i_ready,
    output itbd_pkg::t_char       o_out_char,
    output logic                  o_is_last,
    output logic                  o_invalid_base
);
    import itbd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_PUT  = 3'd4;

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam int AW = $clog2(MAX_DIGITS);

    // configuration registers
    logic [63:0] r_alpha_low;
    logic [63:0] r_alpha_high;
    logic [4:0]  r_base_size;

    // sequencer state
    logic [2:0]    r_state;
    logic          r_neg;
    logic          r_bad;
    logic [4:0]    r_radix;
    logic [31:0]   r_mag;
    logic [3:0]    r_rem;
    logic [2:0]    r_step;
    logic [CW-1:0] r_count;
    logic [3:0]    r_rd_digit;

    // output register
    logic          r_out_valid;
    t_char         r_out_char;
    logic          r_out_last;
    logic          r_out_bad;

    logic [3:0]    digit_mem [MAX_DIGITS];

    logic          cfg_wr;
    logic [1:0]    cfg_idx;
    logic          in_take;
    logic          out_free;
    logic          out_load;
    logic [127:0]  alpha_all;

    // alphabet check
    logic [4:0]    lim;
    logic [4:0]    len;
    logic          alpha_ok;
    t_char         abyte [ALPHA_BYTES];

    // divider step
    logic [3:0]    n_rem;
    logic [3:0]    q_bits;
    logic [4:0]    trial;
    logic [31:0]   n_mag;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[4:3];
    assign cfg_wr   = psel & penable & pwrite;
    assign o_ready  = (r_state == ST_IDLE);
    assign in_take  = i_valid & o_ready;
    assign out_free = ~r_out_valid | i_ready;
    // a new word goes into the output register this cycle
    assign out_load = out_free & (((r_state == ST_SIGN) & (r_bad | r_neg)) |
                                  (r_state == ST_PUT));
    assign alpha_all = {r_alpha_high, r_alpha_low};

    assign o_valid        = r_out_valid;
    assign o_out_char     = r_out_char;
    assign o_is_last      = r_out_last;
    assign o_invalid_base = r_out_bad;

    always_comb begin
        case (cfg_idx)
            REG_ALPHA_LOW:  prdata = r_alpha_low;
            REG_ALPHA_HIGH: prdata = r_alpha_high;
            REG_BASE_SIZE:  prdata = {59'd0, r_base_size};
            default:        prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_low  <= 64'd0;
            r_alpha_high <= 64'd0;
            r_base_size  <= 5'd0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ALPHA_LOW:  r_alpha_low  <= pwdata;
                REG_ALPHA_HIGH: r_alpha_high <= pwdata;
                REG_BASE_SIZE:  r_base_size  <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // alphabet length and validity
    always_comb begin
        for (int k = 0; k < ALPHA_BYTES; k++) begin
            abyte[k] = alpha_all[k*8 +: 8];
        end
        lim = (r_base_size > 5'(MAX_RADIX)) ? 5'(MAX_RADIX) : r_base_size;
        len = lim;
        // first zero byte inside the limit ends the alphabet
        for (int k = ALPHA_BYTES - 1; k >= 0; k--) begin
            if (abyte[k] == 8'd0 && 5'(k) < lim) begin
                len = 5'(k);
            end
        end
        alpha_ok = (len >= 5'd2);
        for (int i = 0; i < ALPHA_BYTES; i++) begin
            if (5'(i) < len && (abyte[i] == CH_PLUS || abyte[i] == CH_MINUS)) begin
                alpha_ok = 1'b0;
            end
            for (int j = i + 1; j < ALPHA_BYTES; j++) begin
                if (5'(j) < len && abyte[i] == abyte[j]) begin
                    alpha_ok = 1'b0;
                end
            end
        end
    end

    // four restoring division steps per cycle
    always_comb begin
        n_rem  = r_rem;
        q_bits = 4'd0;
        trial  = 5'd0;
        for (int b = 0; b < 4; b++) begin
            trial = {n_rem, r_mag[31-b]};
            if (trial >= r_radix) begin
                n_rem      = 4'(trial - r_radix);
                q_bits[3-b] = 1'b1;
            end else begin
                n_rem = trial[3:0];
            end
        end
        n_mag = {r_mag[27:0], q_bits};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && r_step == 3'd7) begin
            digit_mem[r_count[AW-1:0]] <= n_rem;
        end
        if (r_state == ST_RD) begin
            r_rd_digit <= digit_mem[AW'(r_count - CW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_neg       <= 1'b0;
            r_bad       <= 1'b0;
            r_radix     <= 5'd0;
            r_mag       <= 32'd0;
            r_rem       <= 4'd0;
            r_step      <= 3'd0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_take) begin
                        r_neg   <= i_value[31];
                        r_bad   <= ~alpha_ok;
                        r_radix <= len;
                        r_mag   <= i_value[31] ? (32'd0 - i_value) : i_value;
                        r_rem   <= 4'd0;
                        r_step  <= 3'd0;
                        r_count <= '0;
                        r_state <= alpha_ok ? ST_DIV : ST_SIGN;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_rem   <= 4'd0;
                        r_count <= r_count + CW'(1);
                        if (n_mag == 32'd0 || (r_count + CW'(1)) >= CW'(MAX_DIGITS)) begin
                            r_state <= ST_SIGN;
                        end
                    end else begin
                        r_rem <= n_rem;
                    end
                    r_mag <= n_mag;
                end
                ST_SIGN: begin
                    if (r_bad) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_char  <= 8'd0;
                            r_out_last  <= 1'b1;
                            r_out_bad   <= 1'b1;
                            r_state     <= ST_IDLE;
                        end
                    end else if (r_neg) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_out_char  <= CH_MINUS;
                            r_out_last  <= 1'b0;
                            r_out_bad   <= 1'b0;
                            r_state     <= ST_RD;
                        end
                    end else begin
                        r_state <= ST_RD;
                    end
                end
                ST_RD: begin
                    r_count <= r_count - CW'(1);
                    r_state <= ST_PUT;
                end
                ST_PUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_char  <= alpha_all[{r_rd_digit, 3'b000} +: 8];
                        r_out_last  <= (r_count == '0);
                        r_out_bad   <= 1'b0;
                        r_state     <= (r_count == '0) ? ST_IDLE : ST_RD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/itbd_checker.sv @@
// port-level checks for the integer to base digits block, with its bind
`timescale 1ns / 1ps
`default_nettype none
module itbd_checker (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    input  wire                   o_ready,
    input  wire                   o_valid,
    input  wire                   i_ready,
    input  itbd_pkg::t_char       o_out_char,
    input  wire                   o_is_last,
    input  wire                   o_invalid_base
);
    import itbd_pkg::*;

    // an invalid alphabet word is a lone zero char closing its value
    a_bad_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid_base |-> o_out_char == 8'd0 && o_is_last)
        else $error("invalid word not a lone zero char");

    // the minus sign is always followed by digits
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid_base && o_out_char == CH_MINUS |-> !o_is_last)
        else $error("minus sign closed a value");

    // a taken word starts a conversion, so the block is busy next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after a word was taken");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_char)
            && $stable(o_is_last) && $stable(o_invalid_base))
        else $error("stalled output word changed");

endmodule

bind integer_to_base_digits_core itbd_checker u_itbd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_out_char     (o_out_char),
    .o_is_last      (o_is_last),
    .o_invalid_base (o_invalid_base)
);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// self-checking testbench for the integer to base digits core
`timescale 1ns / 1ps
module tb_top;
    import itbd_pkg::*;

    localparam int RADIX_CAP = 16;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        t_char ch;
        logic  last;
        logic  inv;
    } t_char_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_value = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_char       o_out_char;
    logic        o_is_last;
    logic        o_invalid_base;

    integer_to_base_digits_core #(
        .MAX_RADIX(RADIX_CAP)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_value(i_value),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_out_char(o_out_char),
        .o_is_last(o_is_last),
        .o_invalid_base(o_invalid_base)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register copies as the block should hold them
    logic [63:0] cfg_alpha_lo = '0;
    logic [63:0] cfg_alpha_hi = '0;
    logic [4:0]  cfg_base_size = '0;

    logic [31:0] values_to_send[$];
    t_char_word  spelled_chars[$];
    int          mismatches = 0;
    bit          quiet = 1'b0;
    int          src_gap = 0;
    int          snk_gap = 0;

    function automatic t_char alpha_at(int k);
        logic [127:0] a;
        a = {cfg_alpha_hi, cfg_alpha_lo};
        return a[8*(k & 15) +: 8];
    endfunction

    // radix of the current alphabet, 0 when the alphabet is unusable
    function automatic int radix_now();
        int   lim;
        int   len;
        t_char c;
        lim = int'(cfg_base_size);
        if (lim > RADIX_CAP) lim = RADIX_CAP;
        len = 0;
        while (len < lim && alpha_at(len) != 8'h00) len++;
        if (len < 2) return 0;
        for (int i = 0; i < len; i++) begin
            c = alpha_at(i);
            if (c == CH_PLUS || c == CH_MINUS) return 0;
            for (int j = i + 1; j < len; j++)
                if (alpha_at(j) == c) return 0;
        end
        return len;
    endfunction

    function automatic void spell_value(logic [31:0] v);
        logic [31:0] mag;
        logic [31:0] rad;
        logic [3:0]  digs [MAX_DIGITS];
        int          n;
        int          r;
        r = radix_now();
        if (r == 0) begin
            spelled_chars.push_back('{ch: 8'h00, last: 1'b1, inv: 1'b1});
            return;
        end
        rad = r;
        mag = v[31] ? 32'd0 - v : v;
        n = 0;
        do begin
            digs[n] = 4'(mag % rad);
            mag = mag / rad;
            n++;
        end while (mag != 0 && n < MAX_DIGITS);
        if (v[31])
            spelled_chars.push_back('{ch: CH_MINUS, last: 1'b0, inv: 1'b0});
        for (int k = n; k > 0; k--)
            spelled_chars.push_back('{ch: alpha_at(digs[k-1]), last: k == 1, inv: 1'b0});
    endfunction

    // value driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) spell_value(i_value);
            if (!i_valid || o_ready) begin
                if (src_gap != 0) begin
                    src_gap--;
                    i_valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 5) == 0) begin
                    src_gap = $urandom_range(0, 16);
                    i_valid <= 1'b0;
                end else if (values_to_send.size() != 0) begin
                    i_valid <= 1'b1;
                    i_value <= values_to_send.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // character monitor and checker
    always @(posedge i_clk) begin
        t_char_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (spelled_chars.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: char %h last %b invalid %b",
                                 o_out_char, o_is_last, o_invalid_base);
                end else begin
                    want = spelled_chars.pop_front();
                    if (o_out_char !== want.ch || o_is_last !== want.last ||
                        o_invalid_base !== want.inv) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp char %h last %b invalid %b, got %h %b %b",
                                     want.ch, want.last, want.inv,
                                     o_out_char, o_is_last, o_invalid_base);
                    end
                end
            end
            if (snk_gap != 0) begin
                snk_gap--;
                i_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                snk_gap = $urandom_range(0, 16);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ALPHA_LOW:  cfg_alpha_lo = data;
            REG_ALPHA_HIGH: cfg_alpha_hi = data;
            REG_BASE_SIZE:  cfg_base_size = data[4:0];
            default: ;
        endcase
    endtask

    task automatic set_alphabet(input logic [127:0] alpha, input logic [4:0] n);
        write_reg(REG_ALPHA_LOW, alpha[63:0]);
        write_reg(REG_ALPHA_HIGH, alpha[127:64]);
        write_reg(REG_BASE_SIZE, 64'(n));
    endtask

    // wait until every word sent has been spelled out and checked
    task automatic drain();
        do @(negedge i_clk);
        while (values_to_send.size() != 0 || i_valid || spelled_chars.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_value();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 300);
            2: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h0000_0000;
                    1: v = 32'h0000_0001;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if ($urandom_range(0, 1) == 1) v = 32'd0 - v;
        return v;
    endfunction

    localparam logic [127:0] DEC_ALPHA = 128'h3938_3736353433323130;
    localparam logic [127:0] HEX_ALPHA = 128'h4645444342413938_3736353433323130;

    initial begin
        logic [127:0] alpha;
        logic [7:0]   b;
        logic [4:0]   bsz;
        int           n;
        int           kind;
        int           z;
        bit           fresh;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // alphabet empty after reset
        values_to_send.push_back(32'h0000_0000);
        values_to_send.push_back(32'h8000_0000);
        drain();

        set_alphabet(DEC_ALPHA, 5'd10);
        values_to_send = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                           32'd10, 32'hFFFF_FFF6, 32'd9};
        drain();

        set_alphabet(128'h3130, 5'd2);
        values_to_send = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'h0};
        drain();

        set_alphabet(HEX_ALPHA, 5'd16);
        values_to_send = '{32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678};
        drain();

        // base size above the radix cap, plus a write past the register list
        write_reg(REG_BASE_SIZE, 64'd31);
        write_reg(REG_UNUSED, '1);
        values_to_send.push_back(32'h8000_0000);
        drain();

        // repeated digit
        alpha = DEC_ALPHA;
        alpha[79:72] = 8'h30;
        set_alphabet(alpha, 5'd10);
        values_to_send.push_back(32'hFFFF_FFFB);
        drain();

        // sign characters in the alphabet
        set_alphabet(128'h2B30, 5'd2);
        values_to_send.push_back(32'd7);
        drain();
        set_alphabet(128'h302D, 5'd2);
        values_to_send.push_back(32'd7);
        drain();

        // too short: one digit, none, zero byte right after digit 0
        set_alphabet(HEX_ALPHA, 5'd1);
        values_to_send.push_back(32'd3);
        drain();
        write_reg(REG_BASE_SIZE, 64'd0);
        values_to_send.push_back(32'd3);
        drain();
        alpha = HEX_ALPHA;
        alpha[15:8] = 8'h00;
        set_alphabet(alpha, 5'd16);
        values_to_send.push_back(32'd3);
        drain();

        // zero byte cuts the hex alphabet down to radix 5
        alpha = HEX_ALPHA;
        alpha[47:40] = 8'h00;
        set_alphabet(alpha, 5'd16);
        values_to_send.push_back(32'h8000_0000);
        drain();

        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 9) quiet = 1'b1;
            kind = $urandom_range(0, 9);
            n = (kind == 0) ? 16 : $urandom_range(2, 16);
            alpha = {$urandom, $urandom, $urandom, $urandom};
            for (int i = 0; i < n; i++) begin
                do begin
                    b = 8'($urandom_range(1, 255));
                    fresh = (b != CH_PLUS && b != CH_MINUS);
                    for (int j = 0; j < i; j++)
                        if (alpha[8*j +: 8] == b) fresh = 1'b0;
                end while (!fresh);
                alpha[8*i +: 8] = b;
            end
            bsz = 5'(n);
            case (kind)
                0: bsz = 5'($urandom_range(16, 31));
                1: alpha[8*$urandom_range(0, n-1) +: 8] = 8'h00;
                2: begin
                    z = $urandom_range(1, n-1);
                    alpha[8*z +: 8] = alpha[8*$urandom_range(0, z-1) +: 8];
                end
                3: alpha[8*$urandom_range(0, n-1) +: 8] =
                       ($urandom_range(0, 1) == 1) ? CH_PLUS : CH_MINUS;
                4: bsz = 5'($urandom_range(0, 1));
                default: ;
            endcase
            set_alphabet(alpha, bsz);
            for (int k = 0; k < 8; k++) values_to_send.push_back(random_value());
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && spelled_chars.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
